// ===== hw/rtl/hdlb_pkg.sv =====
// ----------------------------------------------------------------------------
// hdlb_pkg
// Shared types, codes and constants of the half-duplex line bidding controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlb_pkg;

	// Width of the saturating wait timer.
	localparam int TIMER_W = 16;
	// Width of the timeout registers.
	localparam int TOUT_W = 16;
	// Width at which the timer is compared against a timeout.
	localparam int CMP_W = (TIMER_W > TOUT_W) ? TIMER_W : TOUT_W;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Link states.
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_BID       = 3'd1;
	localparam logic [2:0] ST_SEND      = 3'd2;
	localparam logic [2:0] ST_CONFIRM   = 3'd3;
	localparam logic [2:0] ST_LINKRESET = 3'd4;
	localparam logic [2:0] ST_RECEIVE   = 3'd5;

	// Event kinds.
	localparam logic [1:0] EV_TICK  = 2'd0;
	localparam logic [1:0] EV_FRAME = 2'd1;
	localparam logic [1:0] EV_RVI   = 2'd2;

	// Received frame kinds.
	localparam logic [2:0] FR_ENQ  = 3'd0;
	localparam logic [2:0] FR_ACK  = 3'd1;
	localparam logic [2:0] FR_EOT  = 3'd2;
	localparam logic [2:0] FR_DATA = 3'd3;
	localparam logic [2:0] FR_RVI  = 3'd4;

	// Upload queue head kinds.
	localparam logic [1:0] UP_EMPTY = 2'd0;
	localparam logic [1:0] UP_DATA  = 2'd1;
	localparam logic [1:0] UP_EOT   = 2'd2;

	// Frames to transmit.
	localparam logic [2:0] TX_NONE = 3'd0;
	localparam logic [2:0] TX_ENQ  = 3'd1;
	localparam logic [2:0] TX_ACK  = 3'd2;
	localparam logic [2:0] TX_EOT  = 3'd3;
	localparam logic [2:0] TX_DATA = 3'd4;

	// Reported events.
	localparam logic [1:0] EC_NONE    = 2'd0;
	localparam logic [1:0] EC_SENT    = 2'd1;
	localparam logic [1:0] EC_CORRUPT = 2'd2;
	localparam logic [1:0] EC_RECV    = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL   = 3'd4;

	// Frame count saturation value.
	localparam logic [3:0] FRAME_CNT_MAX = 4'd15;
	localparam logic [1:0] FAIL_CNT_MAX = 2'd3;

	typedef struct packed {
		logic [TOUT_W-1:0] timeout_ticks;
		logic [TOUT_W-1:0] rx_timeout_ticks;
		logic [3:0]        max_frames_per_turn;
		logic [1:0]        max_retries;
		logic [1:0]        max_failures;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         link_state;
		logic [TIMER_W-1:0] wait_timer;
		logic [3:0]         frame_count;
		logic [1:0]         retry_count;
		logic [1:0]         fail_count;
		logic               enq_pending;
	} link_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [2:0] frame_kind;
		logic       crc_ok;
		logic [1:0] upload_kind;
	} item_t;

	typedef struct packed {
		logic [2:0] send_kind;
		logic       pop_upload;
		logic       consume_rx;
		logic       deliver_data;
		logic [1:0] event_code;
		logic [2:0] state_now;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hdlb_if.sv =====
// ----------------------------------------------------------------------------
// hdlb_if
// Valid/ready channels of the line bidding controller: events, actions and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Event channel: one input item per handshake.
interface hdlb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [2:0] frame_kind;
	logic       crc_ok;
	logic [1:0] upload_kind;

	modport source (output valid, output event_kind, output frame_kind, output crc_ok,
		output upload_kind, input ready);
	modport sink (input valid, input event_kind, input frame_kind, input crc_ok,
		input upload_kind, output ready);
endinterface

// Action channel: one result item per handshake.
interface hdlb_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] send_kind;
	logic       pop_upload;
	logic       consume_rx;
	logic       deliver_data;
	logic [1:0] event_code;
	logic [2:0] state_now;

	modport source (output valid, output send_kind, output pop_upload, output consume_rx,
		output deliver_data, output event_code, output state_now, input ready);
	modport sink (input valid, input send_kind, input pop_upload, input consume_rx,
		input deliver_data, input event_code, input state_now, output ready);
endinterface

// Configuration write channel.
interface hdlb_cfg_if;
	import hdlb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/half_duplex_line_bid_fsm.sv =====
// ----------------------------------------------------------------------------
// half_duplex_line_bid_fsm
// Half-duplex link controller with ENQ/ACK/EOT line bidding and reverse
// interrupt. Each event yields exactly one action item.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake    Payload
//  events    in   valid/ready  event_kind, frame_kind, crc_ok, upload_kind
//  actions   out  valid/ready  send_kind, pop_upload, consume_rx, deliver_data,
//                              event_code, state_now
//  cfg       in   valid/ready  index, data (always ready)
//
// An event is registered on acceptance and its action is registered when it leaves
// the input register, which waits while the action register is full and stalled.
// The controller takes one event per cycle while actions are not stalled; the link
// state update sits between the input register and the action register.
// A stalled action register holds the event in the input register and drops
// events ready only when both registers are full and the action is stalled.
// Reset clears the link state and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module half_duplex_line_bid_fsm (
	input  wire             clk,
	input  wire             arst_n,
	hdlb_item_if.sink       events,
	hdlb_result_if.source   actions,
	hdlb_cfg_if.sink        cfg
);
	import hdlb_pkg::*;

	cfg_t    cfg_q;
	link_t   link_q;
	link_t   link_nxt;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_nxt;
	result_t res_q;
	logic    res_vld_q;
	logic    adv;

	// The input stage moves on when the action register is empty or drains.
	assign adv = vld_s1 && (!res_vld_q || actions.ready);
	assign events.ready = !vld_s1 || adv;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks       <= TOUT_W'(100);
			cfg_q.rx_timeout_ticks    <= TOUT_W'(300);
			cfg_q.max_frames_per_turn <= 4'd10;
			cfg_q.max_retries         <= 2'd3;
			cfg_q.max_failures        <= 2'd3;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TIMEOUT:    cfg_q.timeout_ticks       <= cfg.data[TOUT_W-1:0];
				REG_RX_TIMEOUT: cfg_q.rx_timeout_ticks    <= cfg.data[TOUT_W-1:0];
				REG_MAX_FRAMES: cfg_q.max_frames_per_turn <= cfg.data[3:0];
				REG_MAX_RETRY:  cfg_q.max_retries         <= cfg.data[1:0];
				REG_MAX_FAIL:   cfg_q.max_failures        <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (events.ready) begin
			vld_s1 <= events.valid;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1.event_kind  <= events.event_kind;
			item_s1.frame_kind  <= events.frame_kind;
			item_s1.crc_ok      <= events.crc_ok;
			item_s1.upload_kind <= events.upload_kind;
		end
	end

	// Transition logic for the registered event.
	hdlb_step u_step (
		.cfg_regs (cfg_q),
		.cur      (link_q),
		.item     (item_s1),
		.nxt      (link_nxt),
		.res      (res_nxt)
	);

	// Link state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (adv) begin
			link_q <= link_nxt;
		end
	end

	// Action register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (actions.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// Action register: payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign actions.valid        = res_vld_q;
	assign actions.send_kind    = res_q.send_kind;
	assign actions.pop_upload   = res_q.pop_upload;
	assign actions.consume_rx   = res_q.consume_rx;
	assign actions.deliver_data = res_q.deliver_data;
	assign actions.event_code   = res_q.event_code;
	assign actions.state_now    = res_q.state_now;

	// The link state never leaves the six defined states.
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		link_q.link_state <= ST_RECEIVE)
		else $error("link state outside the defined set");

	// Every event that leaves the input register lands in the action register.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_vld_q)
		else $error("advanced event produced no action");

	// Delivered data is always acknowledged to the peer.
	a_deliver_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.deliver_data) |-> (res_q.send_kind == TX_ACK))
		else $error("data delivered without ACK");

	// A pending ENQ is only recorded on the way back to idle.
	a_enq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(link_q.enq_pending) |-> (link_q.link_state == ST_IDLE))
		else $error("pending ENQ recorded outside idle");

	// A popped upload entry was either confirmed or was the EOT marker.
	a_pop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.pop_upload)
			|-> (res_q.event_code == EC_SENT || res_q.send_kind == TX_EOT))
		else $error("upload entry popped without cause");

endmodule

`default_nettype wire

// ===== hw/rtl/hdlb_step.sv =====
// ----------------------------------------------------------------------------
// hdlb_step
// Next-state and action logic of the link controller for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlb_step (
	input  hdlb_pkg::cfg_t    cfg_regs,
	input  hdlb_pkg::link_t   cur,
	input  hdlb_pkg::item_t   item,
	output hdlb_pkg::link_t   nxt,
	output hdlb_pkg::result_t res
);
	import hdlb_pkg::*;

	logic               tick;
	logic               frame;
	logic               rvi;
	logic [TIMER_W-1:0] timer_inc;
	logic               exp_tx;
	logic               exp_rx;
	logic [3:0]         frame_inc;
	logic [1:0]         fail_inc;

	// Event decode and the shared counter arithmetic.
	always_comb begin
		tick  = (item.event_kind == EV_TICK);
		frame = (item.event_kind == EV_FRAME);
		rvi   = (item.event_kind == EV_RVI);
		timer_inc = (cur.wait_timer == TIMER_MAX) ? cur.wait_timer
			: cur.wait_timer + TIMER_W'(1);
		exp_tx = CMP_W'(timer_inc) >= CMP_W'(cfg_regs.timeout_ticks);
		exp_rx = CMP_W'(timer_inc) >= CMP_W'(cfg_regs.rx_timeout_ticks);
		frame_inc = (cur.frame_count == FRAME_CNT_MAX) ? cur.frame_count
			: cur.frame_count + 4'd1;
		fail_inc = (cur.fail_count == FAIL_CNT_MAX) ? cur.fail_count
			: cur.fail_count + 2'd1;
	end

	// State transitions. Entering a state always clears the wait timer.
	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.link_state)
			ST_IDLE: begin
				if (rvi) begin
					nxt.enq_pending = 1'b0;
					res.send_kind = TX_ENQ;
					nxt.link_state = ST_BID;
					nxt.wait_timer = '0;
				end else if (cur.enq_pending) begin
					// An ENQ seen during link reset is answered now.
					nxt.enq_pending = 1'b0;
					res.send_kind = TX_ACK;
					nxt.link_state = ST_RECEIVE;
					nxt.wait_timer = '0;
					nxt.frame_count = '0;
					nxt.fail_count = '0;
				end else if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_ENQ) begin
						res.send_kind = TX_ACK;
						nxt.link_state = ST_RECEIVE;
						nxt.wait_timer = '0;
						nxt.frame_count = '0;
						nxt.fail_count = '0;
					end
				end else if (tick && (item.upload_kind == UP_DATA
						|| item.upload_kind == UP_EOT)) begin
					res.send_kind = TX_ENQ;
					nxt.link_state = ST_BID;
					nxt.wait_timer = '0;
				end
			end
			ST_BID: begin
				if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_ACK) begin
						nxt.frame_count = '0;
						nxt.link_state = ST_SEND;
						nxt.wait_timer = '0;
					end
				end else if (tick) begin
					nxt.wait_timer = timer_inc;
					if (exp_tx) begin
						nxt.link_state = ST_LINKRESET;
						nxt.wait_timer = '0;
					end
				end
			end
			ST_SEND: begin
				if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_RVI) begin
						res.send_kind = TX_EOT;
						nxt.link_state = ST_LINKRESET;
						nxt.wait_timer = '0;
					end
				end else if (tick) begin
					if (item.upload_kind == UP_EOT) begin
						res.send_kind = TX_EOT;
						res.pop_upload = 1'b1;
						nxt.link_state = ST_LINKRESET;
						nxt.wait_timer = '0;
					end else if (item.upload_kind == UP_DATA) begin
						res.send_kind = TX_DATA;
						nxt.retry_count = 2'd1;
						nxt.link_state = ST_CONFIRM;
						nxt.wait_timer = '0;
					end else begin
						nxt.wait_timer = timer_inc;
						if (exp_tx) begin
							res.send_kind = TX_EOT;
							nxt.link_state = ST_LINKRESET;
							nxt.wait_timer = '0;
						end
					end
				end
			end
			ST_CONFIRM: begin
				if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_ACK) begin
						res.pop_upload = 1'b1;
						res.event_code = EC_SENT;
						nxt.frame_count = frame_inc;
						nxt.wait_timer = '0;
						if (frame_inc >= cfg_regs.max_frames_per_turn) begin
							res.send_kind = TX_EOT;
							nxt.link_state = ST_LINKRESET;
						end else begin
							nxt.link_state = ST_SEND;
						end
					end
				end else if (tick) begin
					nxt.wait_timer = timer_inc;
					if (exp_tx) begin
						nxt.wait_timer = '0;
						if (cur.retry_count < cfg_regs.max_retries) begin
							res.send_kind = TX_DATA;
							nxt.retry_count = cur.retry_count + 2'd1;
						end else begin
							res.send_kind = TX_EOT;
							nxt.link_state = ST_LINKRESET;
						end
					end
				end
			end
			ST_LINKRESET: begin
				if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_ENQ) begin
						nxt.enq_pending = 1'b1;
					end
					nxt.link_state = ST_IDLE;
					nxt.wait_timer = '0;
				end else if (tick) begin
					nxt.wait_timer = timer_inc;
					if (exp_tx) begin
						nxt.link_state = ST_IDLE;
						nxt.wait_timer = '0;
					end
				end
			end
			ST_RECEIVE: begin
				if (rvi) begin
					res.send_kind = TX_ENQ;
					nxt.link_state = ST_BID;
					nxt.wait_timer = '0;
				end else if (frame) begin
					res.consume_rx = 1'b1;
					if (item.frame_kind == FR_EOT) begin
						nxt.link_state = ST_IDLE;
						nxt.wait_timer = '0;
					end else if (item.frame_kind == FR_DATA) begin
						nxt.wait_timer = '0;
						if (item.crc_ok) begin
							res.send_kind = TX_ACK;
							res.deliver_data = 1'b1;
							res.event_code = EC_RECV;
							nxt.fail_count = '0;
							nxt.frame_count = frame_inc;
							if (frame_inc >= cfg_regs.max_frames_per_turn) begin
								nxt.link_state = ST_IDLE;
							end
						end else begin
							res.event_code = EC_CORRUPT;
							nxt.fail_count = fail_inc;
							if (fail_inc >= cfg_regs.max_failures) begin
								nxt.link_state = ST_IDLE;
							end
						end
					end
				end else if (tick) begin
					nxt.wait_timer = timer_inc;
					if (exp_rx) begin
						nxt.link_state = ST_IDLE;
						nxt.wait_timer = '0;
					end
				end
			end
			default: begin
				nxt.link_state = ST_IDLE;
				nxt.wait_timer = '0;
			end
		endcase
		res.state_now = nxt.link_state;
	end

endmodule

`default_nettype wire
